/* design/ogbd_pkg.sv */
// ============================================================================
// ogbd_pkg
// Shared types, widths and constants of the occupancy grid block downsampler.
// ============================================================================
package ogbd_pkg;

    // Defaults of the top-level parameters
    localparam int MAX_MAP_DIM_DEF = 1024;
    localparam int MAX_STEP_DEF    = 16;

    // Field widths
    localparam int CELL_W     = 8;
    localparam int COST_W     = 8;
    localparam int ELEV_W     = 10;
    localparam int COV_W      = 8;
    localparam int POS_W      = 10;
    localparam int DIM_REG_W  = 11;
    localparam int STEP_REG_W = 5;
    localparam int THR_W      = 8;

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Register reset values
    localparam logic [DIM_REG_W-1:0]  MAP_WIDTH_RST  = DIM_REG_W'(1024);
    localparam logic [DIM_REG_W-1:0]  MAP_HEIGHT_RST = DIM_REG_W'(1024);
    localparam logic [STEP_REG_W-1:0] BLOCK_STEP_RST = STEP_REG_W'(1);
    localparam logic                  ALL_MAPS_RST   = 1'b1;
    localparam logic [THR_W-1:0]      THRESHOLD_RST  = THR_W'(90);

    // Output codes
    localparam int ELEV_SCALE = 4;
    localparam logic [COST_W-1:0] COST_OBSTACLE     = COST_W'(250);
    localparam logic [COST_W-1:0] COST_UNEXPLORED   = COST_W'(125);
    localparam logic [COST_W-1:0] COST_FREE         = COST_W'(0);
    localparam logic [COV_W-1:0]  COVERAGE_EXPLORED = COV_W'(249);
    localparam logic [COV_W-1:0]  COVERAGE_NONE     = COV_W'(0);
    localparam logic [ELEV_W-1:0] ELEV_OBSTACLE     = ELEV_W'(250 * ELEV_SCALE);
    localparam logic [ELEV_W-1:0] ELEV_NONE         = ELEV_W'(0);

    // Register indexes
    typedef enum logic [2:0] {
        REG_MAP_WIDTH  = 3'd0,
        REG_MAP_HEIGHT = 3'd1,
        REG_BLOCK_STEP = 3'd2,
        REG_ALL_MAPS   = 3'd3,
        REG_THRESHOLD  = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_REG_W-1:0]  map_width;
        logic [DIM_REG_W-1:0]  map_height;
        logic [STEP_REG_W-1:0] block_step;
        logic                  all_maps_mode;
        logic [THR_W-1:0]      obstacle_threshold;
    } cfg_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
    } cell_t;

    typedef struct packed {
        logic [COST_W-1:0] cost_value;
        logic [ELEV_W-1:0] elevation_value;
        logic [COV_W-1:0]  coverage_value;
        logic [POS_W-1:0]  out_col;
        logic [POS_W-1:0]  out_row;
        logic              last_of_map;
    } result_t;

    // Where the current cell sits relative to its block
    typedef struct packed {
        logic in_block;
        logic first;
        logic last;
        logic map_last;
    } pos_flags_t;

    // Per-column block flags
    typedef struct packed {
        logic explored;
        logic obstacle;
    } flag_pair_t;

endpackage

/* design/ogbd_stream_if.sv */
// ============================================================================
// ogbd_stream_if
// Valid/ready channel carrying one item of a given payload type.
// ============================================================================
interface ogbd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/ogbd_cfg.sv */
// ============================================================================
// ogbd_cfg
// APB-style register file holding the downsampler configuration.
// ============================================================================
module ogbd_cfg
    import ogbd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg,
    output logic                  step_wr
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // block_step change needs the position counters rebuilt
    assign step_wr = wr && (idx == REG_BLOCK_STEP);

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_MAP_WIDTH:  cfg_next.map_width          = pwdata[DIM_REG_W-1:0];
                REG_MAP_HEIGHT: cfg_next.map_height         = pwdata[DIM_REG_W-1:0];
                REG_BLOCK_STEP: cfg_next.block_step         = pwdata[STEP_REG_W-1:0];
                REG_ALL_MAPS:   cfg_next.all_maps_mode      = pwdata[0];
                REG_THRESHOLD:  cfg_next.obstacle_threshold = pwdata[THR_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.map_width          <= MAP_WIDTH_RST;
            cfg_reg.map_height         <= MAP_HEIGHT_RST;
            cfg_reg.block_step         <= BLOCK_STEP_RST;
            cfg_reg.all_maps_mode      <= ALL_MAPS_RST;
            cfg_reg.obstacle_threshold <= THRESHOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_MAP_WIDTH:  prdata = APB_DATA_W'(cfg_reg.map_width);
            REG_MAP_HEIGHT: prdata = APB_DATA_W'(cfg_reg.map_height);
            REG_BLOCK_STEP: prdata = APB_DATA_W'(cfg_reg.block_step);
            REG_ALL_MAPS:   prdata = APB_DATA_W'(cfg_reg.all_maps_mode);
            REG_THRESHOLD:  prdata = APB_DATA_W'(cfg_reg.obstacle_threshold);
            default:        prdata = '0;
        endcase
    end

endmodule

/* design/ogbd_pos.sv */
// ============================================================================
// ogbd_pos
// Raster position tracker: cell counters, position inside the block and
// block coordinates, plus a bit-serial divider that rebuilds the block
// coordinates after the block edge changes.
// ============================================================================
module ogbd_pos
    import ogbd_pkg::*;
#(
    parameter  int MAX_MAP_DIM = MAX_MAP_DIM_DEF,
    parameter  int MAX_STEP    = MAX_STEP_DEF,
    localparam int CNT_W       = $clog2(MAX_MAP_DIM),
    localparam int STEP_W      = $clog2(MAX_STEP + 1)
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              step_wr,
    input  logic [CNT_W:0]    width,
    input  logic [CNT_W:0]    height,
    input  logic [STEP_W-1:0] step,
    output logic              busy,
    output logic [CNT_W-1:0]  block_col,
    output logic [CNT_W-1:0]  block_row,
    output pos_flags_t        flags
);

    localparam int EXT_W  = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 2;
    localparam int ITER_W = $clog2(CNT_W + 1);

    // Cell counters, offsets inside the block, block coordinates
    logic [CNT_W-1:0]  c_reg, c_next, r_reg, r_next;
    logic [STEP_W-1:0] sc_reg, sc_next, sr_reg, sr_next;
    logic [CNT_W-1:0]  ox_reg, ox_next, oy_reg, oy_next;

    // Divider state
    logic              busy_reg, busy_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0]  qc_reg, qc_next, qr_reg, qr_next;
    logic [STEP_W-1:0] rc_reg, rc_next, rr_reg, rr_next;

    logic [STEP_W:0]   trial_c, trial_r;
    logic              ge_c, ge_r;
    logic [STEP_W-1:0] rem_c, rem_r;

    logic [CNT_W-1:0]  base_c, base_r;
    logic [EXT_W-1:0]  end_c, end_r;
    logic              col_wrap, row_wrap;
    logic [STEP_W-1:0] sc_inc, sr_inc;

    assign busy      = busy_reg;
    assign block_col = ox_reg;
    assign block_row = oy_reg;

    // Block fit and last-block checks from the block's first cell
    assign base_c = c_reg - CNT_W'(sc_reg);
    assign base_r = r_reg - CNT_W'(sr_reg);
    assign end_c  = EXT_W'(base_c) + EXT_W'(step);
    assign end_r  = EXT_W'(base_r) + EXT_W'(step);
    assign sc_inc = sc_reg + 1'b1;
    assign sr_inc = sr_reg + 1'b1;

    always_comb
    begin
        flags.in_block = (end_c <= EXT_W'(width)) && (end_r <= EXT_W'(height));
        flags.first    = (sc_reg == '0) && (sr_reg == '0);
        flags.last     = (sc_inc == step) && (sr_inc == step);
        flags.map_last = (end_c + EXT_W'(step) > EXT_W'(width))
                      && (end_r + EXT_W'(step) > EXT_W'(height));
    end

    assign col_wrap = ((CNT_W + 1)'(c_reg) + 1'b1) >= width;
    assign row_wrap = ((CNT_W + 1)'(r_reg) + 1'b1) >= height;

    // One restoring-division step per lane
    assign trial_c = {rc_reg, qc_reg[CNT_W-1]};
    assign trial_r = {rr_reg, qr_reg[CNT_W-1]};
    assign ge_c    = trial_c >= {1'b0, step};
    assign ge_r    = trial_r >= {1'b0, step};
    assign rem_c   = ge_c ? STEP_W'(trial_c - {1'b0, step}) : STEP_W'(trial_c);
    assign rem_r   = ge_r ? STEP_W'(trial_r - {1'b0, step}) : STEP_W'(trial_r);

    // Next state
    always_comb
    begin
        c_next    = c_reg;
        r_next    = r_reg;
        sc_next   = sc_reg;
        sr_next   = sr_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        qc_next   = qc_reg;
        qr_next   = qr_reg;
        rc_next   = rc_reg;
        rr_next   = rr_reg;
        if (step_wr)
        begin
            // start rebuilding offsets and block coordinates
            busy_next = 1'b1;
            cnt_next  = ITER_W'(CNT_W);
            qc_next   = c_reg;
            qr_next   = r_reg;
            rc_next   = '0;
            rr_next   = '0;
        end
        else if (busy_reg)
        begin
            qc_next  = {qc_reg[CNT_W-2:0], ge_c};
            qr_next  = {qr_reg[CNT_W-2:0], ge_r};
            rc_next  = rem_c;
            rr_next  = rem_r;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == ITER_W'(1))
            begin
                busy_next = 1'b0;
                ox_next   = {qc_reg[CNT_W-2:0], ge_c};
                oy_next   = {qr_reg[CNT_W-2:0], ge_r};
                sc_next   = rem_c;
                sr_next   = rem_r;
            end
        end
        else if (advance)
        begin
            if (col_wrap)
            begin
                c_next  = '0;
                sc_next = '0;
                ox_next = '0;
                if (row_wrap)
                begin
                    r_next  = '0;
                    sr_next = '0;
                    oy_next = '0;
                end
                else
                begin
                    r_next = r_reg + 1'b1;
                    if (sr_inc == step)
                    begin
                        sr_next = '0;
                        oy_next = oy_reg + 1'b1;
                    end
                    else
                    begin
                        sr_next = sr_inc;
                    end
                end
            end
            else
            begin
                c_next = c_reg + 1'b1;
                if (sc_inc == step)
                begin
                    sc_next = '0;
                    ox_next = ox_reg + 1'b1;
                end
                else
                begin
                    sc_next = sc_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg    <= '0;
            r_reg    <= '0;
            sc_reg   <= '0;
            sr_reg   <= '0;
            ox_reg   <= '0;
            oy_reg   <= '0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            c_reg    <= c_next;
            r_reg    <= r_next;
            sc_reg   <= sc_next;
            sr_reg   <= sr_next;
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        qc_reg <= qc_next;
        qr_reg <= qr_next;
        rc_reg <= rc_next;
        rr_reg <= rr_next;
    end

endmodule

/* design/ogbd_flags.sv */
// ============================================================================
// ogbd_flags
// Per-column obstacle/explored flag memory with read-modify-write and
// forwarding of the write that lands in the same cycle as the next read.
// ============================================================================
module ogbd_flags
    import ogbd_pkg::*;
#(
    parameter  int MAX_MAP_DIM = MAX_MAP_DIM_DEF,
    localparam int CNT_W       = $clog2(MAX_MAP_DIM)
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [CNT_W-1:0] rd_addr,
    input  logic             first,
    input  flag_pair_t       cell_flags,
    input  logic             wr_en,
    input  logic [CNT_W-1:0] wr_addr,
    output flag_pair_t       merged
);

    flag_pair_t flag_mem [MAX_MAP_DIM];

    flag_pair_t rd_data_reg;
    logic       first_reg;
    flag_pair_t new_reg;
    logic       fwd_reg;
    flag_pair_t fwd_data_reg;
    flag_pair_t stored;

    // Stored value: memory, or the write that raced the read
    assign stored = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign merged = first_reg ? new_reg : flag_pair_t'(stored | new_reg);

    // Read port and stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_data_reg  <= flag_mem[rd_addr];
            first_reg    <= first;
            new_reg      <= cell_flags;
            fwd_data_reg <= merged;
        end
    end

    // Forward select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (load)
        begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            flag_mem[wr_addr] <= merged;
        end
    end

endmodule

/* design/occupancy_grid_block_downsampler.sv */
// ============================================================================
// occupancy_grid_block_downsampler
// Block max pooling of an occupancy grid into cost, elevation and coverage.
// ============================================================================
// Usage:
//   cells   - input channel, one occupancy cell per item, raster order with
//             x fastest. Map size and block edge come from the APB registers.
//   results - one item per whole block, sent when the block's bottom-right
//             cell has been taken; cells of partial blocks give nothing.
// Throughput: one cell per cycle unless a result stalls behind a full output
//   register or block_step is being rebuilt. Each whole-block cell does one
//   read-modify-write of the per-column flag memory; a back-to-back access
//   to the same column is served by forwarding. A block's last cell is
//   registered in stage 1 and its result loaded into the output register.
// Stall: a result waits in the output register; cells keep flowing until a
//   second result is ready behind it, then cells stall.
// Writing block_step rebuilds the block coordinates with a bit-serial
//   divider: cells are held off in the write's access cycle and while the
//   divider runs.
// Reset: counters at the map origin, registers at their reset values, no
//   result pending. The flag memory is not cleared; the first cell of each
//   whole block overwrites its column entry.
// ============================================================================
module occupancy_grid_block_downsampler
    import ogbd_pkg::*;
#(
    parameter  int MAX_MAP_DIM = MAX_MAP_DIM_DEF,
    parameter  int MAX_STEP    = MAX_STEP_DEF,
    localparam int CNT_W       = $clog2(MAX_MAP_DIM),
    localparam int STEP_W      = $clog2(MAX_STEP + 1)
)(
    input  logic                  clk,
    input  logic                  rst_n,
    ogbd_stream_if.sink           cells,
    ogbd_stream_if.source         results,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t              cfg;
    logic              step_wr;
    logic [CNT_W:0]    width_eff, height_eff;
    logic [STEP_W-1:0] step_eff;

    logic              pos_busy;
    logic [CNT_W-1:0]  block_col, block_row;
    pos_flags_t        pos_flags;
    cell_t             cell_in;
    flag_pair_t        cell_flags;
    flag_pair_t        merged;

    logic              accept;
    logic              s1_valid_reg, s1_valid_next;
    pos_flags_t        s1_flags_reg;
    logic [CNT_W-1:0]  s1_col_reg, s1_row_reg;
    logic              s1_result, s1_fire, s1_wr;

    logic              out_valid_reg, out_valid_next;
    logic              out_free, out_load;
    result_t           out_data_reg;
    result_t           result;

    // Registers
    ogbd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .step_wr (step_wr)
    );

    // Out-of-range register values clamp to the legal range
    always_comb
    begin
        if (cfg.map_width == '0)
            width_eff = (CNT_W + 1)'(1);
        else if (int'(cfg.map_width) > MAX_MAP_DIM)
            width_eff = (CNT_W + 1)'(MAX_MAP_DIM);
        else
            width_eff = (CNT_W + 1)'(cfg.map_width);

        if (cfg.map_height == '0)
            height_eff = (CNT_W + 1)'(1);
        else if (int'(cfg.map_height) > MAX_MAP_DIM)
            height_eff = (CNT_W + 1)'(MAX_MAP_DIM);
        else
            height_eff = (CNT_W + 1)'(cfg.map_height);

        if (cfg.block_step == '0)
            step_eff = STEP_W'(1);
        else if (int'(cfg.block_step) > MAX_STEP)
            step_eff = STEP_W'(MAX_STEP);
        else
            step_eff = STEP_W'(cfg.block_step);
    end

    // Position tracking
    ogbd_pos #(
        .MAX_MAP_DIM (MAX_MAP_DIM),
        .MAX_STEP    (MAX_STEP)
    ) u_pos (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (accept),
        .step_wr   (step_wr),
        .width     (width_eff),
        .height    (height_eff),
        .step      (step_eff),
        .busy      (pos_busy),
        .block_col (block_col),
        .block_row (block_row),
        .flags     (pos_flags)
    );

    // Input handshake and cell classification
    assign cell_in             = cells.data;
    assign cell_flags.obstacle = cell_in.cell_value > cfg.obstacle_threshold;
    assign cell_flags.explored = cell_in.cell_value != '0;

    assign out_free    = !out_valid_reg || results.ready;
    assign s1_result   = s1_valid_reg && s1_flags_reg.in_block && s1_flags_reg.last;
    assign s1_fire     = s1_valid_reg && (!s1_result || out_free);
    assign s1_wr       = s1_fire && s1_flags_reg.in_block;
    assign cells.ready = !pos_busy && !step_wr && (!s1_valid_reg || s1_fire);
    assign accept      = cells.valid && cells.ready;

    // Flag memory
    ogbd_flags #(
        .MAX_MAP_DIM (MAX_MAP_DIM)
    ) u_flags (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .rd_addr    (block_col),
        .first      (pos_flags.first),
        .cell_flags (cell_flags),
        .wr_en      (s1_wr),
        .wr_addr    (s1_col_reg),
        .merged     (merged)
    );

    // Stage 1 control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_flags_reg <= pos_flags;
            s1_col_reg   <= block_col;
            s1_row_reg   <= block_row;
        end
    end

    // Result encoding
    always_comb
    begin
        result.out_col     = POS_W'(s1_col_reg);
        result.out_row     = POS_W'(s1_row_reg);
        result.last_of_map = s1_flags_reg.map_last;
        if (cfg.all_maps_mode)
        begin
            result.cost_value      = merged.obstacle ? COST_OBSTACLE : COST_FREE;
            result.elevation_value = merged.obstacle ? ELEV_OBSTACLE : ELEV_NONE;
            result.coverage_value  = merged.explored ? COVERAGE_EXPLORED : COVERAGE_NONE;
        end
        else
        begin
            if (merged.obstacle)
                result.cost_value = COST_OBSTACLE;
            else if (merged.explored)
                result.cost_value = COST_FREE;
            else
                result.cost_value = COST_UNEXPLORED;
            result.elevation_value = ELEV_NONE;
            result.coverage_value  = COVERAGE_NONE;
        end
    end

    // Output register
    assign out_load = s1_result && out_free;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= result;
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Checks
    a_step_write_holds_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        step_wr |=> !cells.ready
    ) else $error("item accepted while block coordinates are being rebuilt");

    a_block_end_reaches_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_result && out_free) |=> results.valid
    ) else $error("finished block did not reach the output register");

    a_no_accept_behind_full_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_result && !out_free) |-> !accept
    ) else $error("item accepted behind a stalled result");

endmodule
